/* src/baro_temp_pressure_compensation_core_macros.svh */
// assertion macros shared by the compensation core modules
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BTPC_ASSERT_IMPLIES(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define BTPC_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* src/btpc_pkg.sv */
// shared types and constants of the compensation core
`default_nettype none

package btpc_pkg;

  localparam int RAW_W     = 20;
  localparam int TEMP_W    = 15;
  localparam int PRESS_W   = 32;
  localparam int COEF_W    = 48;
  localparam int CFG_IDX_W = 8;
  localparam int DEN_W     = 31;
  localparam int DIV_STEPS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_MID   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH  = CFG_IDX_W'(3);

  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 15'sd8500;
  localparam logic signed [25:0]       TF_OFFSET = 26'sd128000;
  localparam logic signed [63:0]       V1_BIAS   = 64'sh0000_8000_0000_0000;
  localparam logic [20:0]              P_FULL    = 21'h10_0000;
  localparam logic [PRESS_W-1:0]       PRESS_MAX = '1;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     den_zero;
  } side_t;

endpackage

`default_nettype wire

/* src/btpc_in_if.sv */
// input channel carrying one raw temperature and pressure conversion
`default_nettype none

interface btpc_in_if import btpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

/* src/btpc_out_if.sv */
// output channel carrying one compensated result
`default_nettype none

interface btpc_out_if import btpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [PRESS_W-1:0]       pressure_q24_8;
  logic                     pressure_valid;

  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output pressure_valid, input ready);
  modport sink (input valid, input temperature_centi, input pressure_q24_8,
                input pressure_valid, output ready);
endinterface

`default_nettype wire

/* src/btpc_cfg_if.sv */
// configuration write channel
`default_nettype none

interface btpc_cfg_if import btpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/baro_temp_pressure_compensation_core.sv */
// Barometric compensation core: takes one raw temperature and raw pressure
// conversion per beat and returns temperature in 0.01 degC and pressure in Pa
// as unsigned Q24.8, using twelve calibration coefficients written through
// the configuration channel (index 0 to 3, other indexes ignored). The block
// is a fully pipelined datapath: it accepts one beat per cycle unless the
// result side stalls, which holds the whole pipeline. Each result passes the
// front stages, the 64-stage pipelined divider (one quotient bit per stage)
// and the multiply stages around it; results come out in order. Coefficients
// must be written by the user while no beat is in flight; it is not enforced.
`default_nettype none
`include "baro_temp_pressure_compensation_core_macros.svh"

module baro_temp_pressure_compensation_core import btpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  btpc_in_if.sink   sample,
  btpc_out_if.source result,
  btpc_cfg_if.sink  cfg
);

  logic [COEF_W-1:0] temp_coeffs, press_coeffs_low, press_coeffs_mid, press_coeffs_high;
  coef_t coef;
  logic en;

  logic                     f_valid;
  logic signed [63:0]       f_num;
  logic signed [DEN_W-1:0]  f_den;
  logic signed [TEMP_W-1:0] f_temp;
  logic                     d_valid;
  logic signed [63:0]       d_quot;
  side_t                    d_side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_mid  <= '0;
      press_coeffs_high <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_TEMP_COEFFS: temp_coeffs       <= cfg.data;
        REG_PRESS_LOW:   press_coeffs_low  <= cfg.data;
        REG_PRESS_MID:   press_coeffs_mid  <= cfg.data;
        REG_PRESS_HIGH:  press_coeffs_high <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_coeffs[15:0];
    coef.t2 = $signed(temp_coeffs[31:16]);
    coef.t3 = $signed(temp_coeffs[47:32]);
    coef.p1 = press_coeffs_low[15:0];
    coef.p2 = $signed(press_coeffs_low[31:16]);
    coef.p3 = $signed(press_coeffs_low[47:32]);
    coef.p4 = $signed(press_coeffs_mid[15:0]);
    coef.p5 = $signed(press_coeffs_mid[31:16]);
    coef.p6 = $signed(press_coeffs_mid[47:32]);
    coef.p7 = $signed(press_coeffs_high[15:0]);
    coef.p8 = $signed(press_coeffs_high[31:16]);
    coef.p9 = $signed(press_coeffs_high[47:32]);
  end

  // pipeline advances unless a finished result is held
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  btpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .coef      (coef),
    .in_valid  (sample.valid && sample.ready),
    .raw_t     (sample.raw_temperature),
    .raw_p     (sample.raw_pressure),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_temp  (f_temp)
  );

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .side_in   ('{temp: f_temp, den_zero: 1'b0}),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  btpc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .coef              (coef),
    .in_valid          (d_valid),
    .quot              (d_quot),
    .side_in           (d_side),
    .out_valid         (result.valid),
    .temperature_centi (result.temperature_centi),
    .pressure          (result.pressure_q24_8),
    .pressure_valid    (result.pressure_valid)
  );

  `BTPC_ASSERT_NEXT(a_cfg_temp_write, cfg.valid && cfg.ready && (cfg.index == REG_TEMP_COEFFS), temp_coeffs == $past(cfg.data), "temperature coefficient write lost")
  `BTPC_ASSERT_NEXT(a_cfg_high_write, cfg.valid && cfg.ready && (cfg.index == REG_PRESS_HIGH), press_coeffs_high == $past(cfg.data), "pressure coefficient write lost")

endmodule

`default_nettype wire

/* src/btpc_front.sv */
// temperature compensation and pressure dividend and divisor stages
`default_nettype none

module btpc_front import btpc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire coef_t                    coef,
  input  wire logic                     in_valid,
  input  wire logic [RAW_W-1:0]         raw_t,
  input  wire logic [RAW_W-1:0]         raw_p,
  output logic                          out_valid,
  output logic signed [63:0]            out_num,
  output logic signed [DEN_W-1:0]       out_den,
  output logic signed [TEMP_W-1:0]      out_temp
);

  logic [8:0] v;

  logic signed [17:0] ta_c;
  logic signed [16:0] d_c;
  logic signed [23:0] v2t_c;
  logic signed [27:0] t5_c;
  logic [20:0]        pd_c;
  logic [63:0]        den_c;

  logic signed [33:0] s1_tx, s1_dd;
  logic signed [22:0] s2_v1t;
  logic signed [37:0] s2_m3;
  logic signed [24:0] s3_tf;
  logic signed [25:0] s3_v1;
  logic signed [51:0] s4_sq;
  logic signed [41:0] s4_m5, s4_m2;
  logic signed [19:0] s4_t;
  logic signed [63:0] s5_m6, s5_m3;
  logic signed [41:0] s5_m5, s5_m2;
  logic signed [63:0] s6_v2, s6_x;
  logic signed [63:0] s7_n0;
  logic [47:0]        s7_pl;
  logic [31:0]        s7_ph;
  logic signed [DEN_W-1:0] s8_den, s9_den;
  logic signed [63:0] s8_a, s8_b, s9_num;
  logic [RAW_W-1:0]   adcp_q [1:6];
  logic signed [TEMP_W-1:0] tq [5:9];

  assign ta_c  = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
  assign d_c   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coef.t1});
  assign v2t_c = $signed(s2_m3[37:14]);
  assign t5_c  = s3_tf * 28'sd5 + 28'sd128;
  assign pd_c  = P_FULL - {1'b0, adcp_q[6]};
  assign den_c = {16'b0, s7_pl} + {s7_ph, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature terms
      s1_tx     <= ta_c * coef.t2;
      s1_dd     <= d_c * d_c;
      adcp_q[1] <= raw_p;
      s2_v1t    <= $signed(s1_tx[33:11]);
      s2_m3     <= $signed(s1_dd[33:12]) * coef.t3;
      s3_tf     <= s2_v1t + v2t_c;
      s3_v1     <= s2_v1t + v2t_c - TF_OFFSET;
      // pressure polynomial in the fine temperature
      s4_sq     <= s3_v1 * s3_v1;
      s4_m5     <= s3_v1 * coef.p5;
      s4_m2     <= s3_v1 * coef.p2;
      s4_t      <= t5_c[27:8];
      s5_m6     <= s4_sq * coef.p6;
      s5_m3     <= s4_sq * coef.p3;
      s5_m5     <= s4_m5;
      s5_m2     <= s4_m2;
      if (s4_t < TEMP_MIN) begin
        tq[5] <= TEMP_MIN;
      end else if (s4_t > TEMP_MAX) begin
        tq[5] <= TEMP_MAX;
      end else begin
        tq[5] <= s4_t[TEMP_W-1:0];
      end
      s6_v2     <= s5_m6 + (64'(s5_m5) <<< 17) + (64'(coef.p4) <<< 35);
      s6_x      <= (s5_m3 >>> 8) + (64'(s5_m2) <<< 12) + V1_BIAS;
      // dividend and divisor
      s7_n0     <= $signed({12'b0, pd_c, 31'b0}) - s6_v2;
      s7_pl     <= s6_x[31:0] * coef.p1;
      s7_ph     <= s6_x[63:32] * coef.p1;
      s8_den    <= $signed(den_c[63:33]);
      s8_a      <= (s7_n0 <<< 11) + (s7_n0 <<< 10) + (s7_n0 <<< 5);
      s8_b      <= (s7_n0 <<< 4) + (s7_n0 <<< 2) + s7_n0;
      s9_num    <= s8_a + s8_b;
      s9_den    <= s8_den;
      for (int k = 2; k <= 6; k++) begin
        adcp_q[k] <= adcp_q[k-1];
      end
      for (int k = 6; k <= 9; k++) begin
        tq[k] <= tq[k-1];
      end
    end
  end

  assign out_valid = v[8];
  assign out_num   = s9_num;
  assign out_den   = s9_den;
  assign out_temp  = tq[9];

endmodule

`default_nettype wire

/* src/btpc_div.sv */
// pipelined signed divider, one quotient bit per stage
`default_nettype none
`include "baro_temp_pressure_compensation_core_macros.svh"

module btpc_div import btpc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic signed [63:0]    num,
  input  wire logic signed [DEN_W-1:0] den,
  input  wire side_t                 side_in,
  output logic                       out_valid,
  output logic signed [63:0]         quot,
  output side_t                      side_out
);

  logic [DIV_STEPS:0] vq;
  logic [DEN_W-1:0]   rem_q [0:DIV_STEPS];
  logic [63:0]        dq_q  [0:DIV_STEPS];
  logic [DEN_W-1:0]   mb_q  [0:DIV_STEPS];
  logic               neg_q [0:DIV_STEPS];
  side_t              side_q [0:DIV_STEPS];

  logic [DEN_W:0]     trial_c [0:DIV_STEPS-1];
  logic               ge_c    [0:DIV_STEPS-1];
  logic [DEN_W-1:0]   rem_c   [0:DIV_STEPS-1];
  logic [63:0]        ma_c;
  logic [DEN_W-1:0]   mb_c;
  logic               vo;

  assign ma_c = num[63] ? (64'd0 - $unsigned(num)) : $unsigned(num);
  assign mb_c = den[DEN_W-1] ? (DEN_W'(0) - $unsigned(den)) : $unsigned(den);

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial_c[k] = {rem_q[k], dq_q[k][63]};
      ge_c[k]    = trial_c[k] >= {1'b0, mb_q[k]};
      rem_c[k]   = ge_c[k] ? DEN_W'(trial_c[k] - {1'b0, mb_q[k]}) : trial_c[k][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
      vo <= 1'b0;
    end else if (en) begin
      vq <= {vq[DIV_STEPS-1:0], in_valid};
      vo <= vq[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= '0;
      dq_q[0]   <= ma_c;
      mb_q[0]   <= mb_c;
      neg_q[0]  <= num[63] ^ den[DEN_W-1];
      side_q[0] <= '{temp: side_in.temp, den_zero: (den == '0)};
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k+1]  <= rem_c[k];
        dq_q[k+1]   <= {dq_q[k][62:0], ge_c[k]};
        mb_q[k+1]   <= mb_q[k];
        neg_q[k+1]  <= neg_q[k];
        side_q[k+1] <= side_q[k];
      end
      quot     <= neg_q[DIV_STEPS] ? $signed(64'd0 - dq_q[DIV_STEPS]) : $signed(dq_q[DIV_STEPS]);
      side_out <= side_q[DIV_STEPS];
    end
  end

  assign out_valid = vo;

  `BTPC_ASSERT_IMPLIES(a_rem_below_divisor, vq[DIV_STEPS] && (mb_q[DIV_STEPS] != '0), rem_q[DIV_STEPS] < mb_q[DIV_STEPS], "divider remainder not below divisor")

endmodule

`default_nettype wire

/* src/btpc_back.sv */
// pressure correction terms, saturation and output register
`default_nettype none
`include "baro_temp_pressure_compensation_core_macros.svh"

module btpc_back import btpc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire coef_t                  coef,
  input  wire logic                   in_valid,
  input  wire logic signed [63:0]     quot,
  input  wire side_t                  side_in,
  output logic                        out_valid,
  output logic signed [TEMP_W-1:0]    temperature_centi,
  output logic [PRESS_W-1:0]          pressure,
  output logic                        pressure_valid
);

  logic [5:0] v;

  logic signed [63:0] a_c;
  logic [31:0]        p8x_c, p9x_c;
  logic [63:0]        v2_c, v1_c;
  logic signed [63:0] r_c;

  logic [63:0]        b1_ll;
  logic [31:0]        b1_lh, b1_8h;
  logic signed [48:0] b1_8l;
  logic [63:0]        b2_sq;
  logic signed [44:0] b2_v2, b3_v2, b4_v2;
  logic signed [48:0] b3_9l;
  logic [31:0]        b3_9h;
  logic signed [38:0] b4_v1;
  logic signed [63:0] b5_s;
  logic signed [63:0] qq [1:4];
  side_t              sq [1:5];

  assign a_c   = quot >>> 13;
  assign p8x_c = {{16{coef.p8[15]}}, coef.p8};
  assign p9x_c = {{16{coef.p9[15]}}, coef.p9};
  assign v2_c  = {{15{b1_8l[48]}}, b1_8l} + {b1_8h, 32'b0};
  assign v1_c  = {{15{b3_9l[48]}}, b3_9l} + {b3_9h, 32'b0};
  assign r_c   = (b5_s >>> 8) + (64'(coef.p7) <<< 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // square of the scaled quotient and the p8 term, low 64 bits
      b1_ll <= a_c[31:0] * a_c[31:0];
      b1_lh <= a_c[31:0] * a_c[63:32];
      b1_8l <= $signed({1'b0, quot[31:0]}) * coef.p8;
      b1_8h <= quot[63:32] * p8x_c;
      qq[1] <= quot;
      sq[1] <= side_in;
      b2_sq <= b1_ll + {b1_lh[30:0], 33'b0};
      b2_v2 <= $signed(v2_c[63:19]);
      b3_9l <= $signed({1'b0, b2_sq[31:0]}) * coef.p9;
      b3_9h <= b2_sq[63:32] * p9x_c;
      b3_v2 <= b2_v2;
      b4_v1 <= $signed(v1_c[63:25]);
      b4_v2 <= b3_v2;
      b5_s  <= qq[4] + b4_v1 + b4_v2;
      for (int k = 2; k <= 4; k++) begin
        qq[k] <= qq[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        sq[k] <= sq[k-1];
      end
      // output register
      temperature_centi <= sq[5].temp;
      pressure_valid    <= !sq[5].den_zero;
      if (sq[5].den_zero || r_c[63]) begin
        pressure <= '0;
      end else if (r_c[63:32] != '0) begin
        pressure <= PRESS_MAX;
      end else begin
        pressure <= r_c[31:0];
      end
    end
  end

  assign out_valid = v[5];

  `BTPC_ASSERT_IMPLIES(a_zero_div_no_press, v[5] && !pressure_valid, pressure == '0, "pressure not zero on zero divisor")
  `BTPC_ASSERT_IMPLIES(a_temp_in_range, v[5], (temperature_centi >= TEMP_MIN) && (temperature_centi <= TEMP_MAX), "temperature out of range")

endmodule

`default_nettype wire
